@@ hdl/xse_pkg.sv @@
`default_nettype none

package xse_pkg;

    // Opcodes of the supported subset
    localparam logic [7:0] OPC_NOP       = 8'h90;
    localparam logic [7:0] OPC_MOV_RM8   = 8'h88;
    localparam logic [7:0] OPC_CMP_AL    = 8'h3C;
    localparam logic [7:0] OPC_JZ        = 8'h74;
    localparam logic [7:0] OPC_JNZ       = 8'h75;
    localparam logic [7:0] OPC_JMP_SHORT = 8'hEB;
    localparam logic [7:0] OPC_PUSH_AX   = 8'h50;
    localparam logic [7:0] OPC_POP_AX    = 8'h58;
    localparam logic [7:0] OPC_INT       = 8'hCD;
    localparam logic [7:0] OPC_IRET      = 8'hCF;
    localparam logic [7:0] OPC_RETF      = 8'hCB;
    localparam logic [7:0] OPC_RET       = 8'hC3;
    localparam logic [4:0] OPC_MOV_R8_HI = 5'b10110;  // B0-B7
    localparam logic [4:0] OPC_MOV_R16_HI = 5'b10111; // B8-BF
    localparam logic [1:0] MODRM_MOD_REG = 2'b11;

    localparam logic [7:0] INT_SERVICE   = 8'h21;
    localparam logic [7:0] INT_TERMINATE = 8'h20;

    localparam logic [1:0] TRAP_NONE      = 2'd0;
    localparam logic [1:0] TRAP_SERVICE   = 2'd1;
    localparam logic [1:0] TRAP_TERMINATE = 2'd2;
    localparam logic [1:0] TRAP_OTHER     = 2'd3;

    // FLAGS bit positions
    localparam int CF_POS = 0;
    localparam int ZF_POS = 6;
    localparam int SF_POS = 7;

    localparam logic [2:0] REG_SP = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_CS = 2'd0;
    localparam logic [1:0] CFG_START_IP = 2'd1;
    localparam logic [1:0] CFG_START_SP = 2'd2;
    localparam logic [1:0] CFG_STACK_SEG = 2'd3;

    localparam logic [15:0] RST_CS    = 16'h2000;
    localparam logic [15:0] RST_IP    = 16'h0100;
    localparam logic [15:0] RST_SP    = 16'hFFFE;
    localparam logic [15:0] RST_SS    = 16'h2000;
    localparam logic [15:0] RST_FLAGS = 16'h0200;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MOV_R8_IMM,
        OP_MOV_R16_IMM,
        OP_MOV_RR8,
        OP_MOV_MEM,
        OP_CMP_AL,
        OP_JZ,
        OP_JNZ,
        OP_JMP,
        OP_PUSH,
        OP_POP,
        OP_INT,
        OP_IRET,
        OP_RETF,
        OP_RET,
        OP_UNKNOWN
    } op_class_t;

    // Decoded instruction handed from front to back
    typedef struct packed {
        op_class_t   op;
        logic [1:0]  len;
        logic [2:0]  dst;
        logic [2:0]  src;
        logic [15:0] imm;
        logic [1:0]  trap;
        logic [15:0] top;
        logic [15:0] second;
        logic [15:0] third;
    } uop_t;

endpackage

`default_nettype wire

@@ hdl/x86_subset_instruction_executor.sv @@
`default_nettype none

// Executes a small subset of 8086 real-mode instructions, one request per
// instruction: the request carries the opcode, up to two operand bytes and the
// three stack words at SS:SP; the result gives the new IP and CS, the PUSH
// stack write, an INT trap code and AX, DX and FLAGS. Throughput is one
// instruction per clock while out_ready does not stall the result. A request
// is decoded in the front stage and parked in a QUEUE_DEPTH-entry queue; the
// back stage executes one queued instruction per cycle unless the output is
// stalled, against the register state, and lands it in an output register.
// The back stage updates IP, SP, FLAGS and the byte registers together for
// each instruction, which sets that rate. Configuration writes (start CS, IP,
// SP and the stack segment) take effect at the next edge and must only be issued while idle.
module x86_subset_instruction_executor #(
    parameter int QUEUE_DEPTH = xse_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  opcode,
    input  wire logic [7:0]  operand_one,
    input  wire logic [7:0]  operand_two,
    input  wire logic [15:0] stack_top,
    input  wire logic [15:0] stack_second,
    input  wire logic [15:0] stack_third,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      next_offset,
    output logic [15:0]      code_segment,
    output logic             mem_write,
    output logic [20:0]      write_address,
    output logic [15:0]      write_data,
    output logic [1:0]       trap_kind,
    output logic             recognized,
    output logic [15:0]      acc_value,
    output logic [15:0]      data_value,
    output logic [15:0]      flags_value
);
    import xse_pkg::*;

    // front -> queue
    logic q_full;
    logic q_push;
    uop_t push_uop;

    // queue -> back
    logic q_not_empty;
    logic q_pop;
    uop_t head_uop;

    // Decode and accept
    xse_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .operand_one  (operand_one),
        .operand_two  (operand_two),
        .stack_top    (stack_top),
        .stack_second (stack_second),
        .stack_third  (stack_third),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_uop        (push_uop)
    );

    // Decoupling queue between decode and execute
    xse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_uop  (push_uop),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_uop  (head_uop)
    );

    // Execute, architectural state and result register
    xse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_uop         (head_uop),
        .q_pop         (q_pop),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .next_offset   (next_offset),
        .code_segment  (code_segment),
        .mem_write     (mem_write),
        .write_address (write_address),
        .write_data    (write_data),
        .trap_kind     (trap_kind),
        .recognized    (recognized),
        .acc_value     (acc_value),
        .data_value    (data_value),
        .flags_value   (flags_value)
    );

endmodule

`default_nettype wire

@@ hdl/xse_front.sv @@
`default_nettype none

module xse_front (
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   opcode,
    input  wire logic [7:0]   operand_one,
    input  wire logic [7:0]   operand_two,
    input  wire logic [15:0]  stack_top,
    input  wire logic [15:0]  stack_second,
    input  wire logic [15:0]  stack_third,
    input  wire logic         q_full,
    output logic              q_push,
    output xse_pkg::uop_t     q_uop
);
    import xse_pkg::*;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_uop        = '0;
        q_uop.imm    = {operand_two, operand_one};
        q_uop.top    = stack_top;
        q_uop.second = stack_second;
        q_uop.third  = stack_third;
        q_uop.dst    = opcode[2:0];
        q_uop.src    = operand_one[5:3];
        q_uop.trap   = TRAP_NONE;
        q_uop.len    = 2'd1;
        q_uop.op     = OP_UNKNOWN;

        priority if (opcode[7:3] == OPC_MOV_R8_HI)
        begin
            q_uop.op  = OP_MOV_R8_IMM;
            q_uop.len = 2'd2;
        end
        else if (opcode[7:3] == OPC_MOV_R16_HI)
        begin
            q_uop.op  = OP_MOV_R16_IMM;
            q_uop.len = 2'd3;
        end
        else
        begin
            unique case (opcode)
                OPC_NOP: q_uop.op = OP_NOP;
                OPC_MOV_RM8:
                begin
                    q_uop.len = 2'd2;
                    q_uop.dst = operand_one[2:0];
                    q_uop.op  = (operand_one[7:6] == MODRM_MOD_REG) ? OP_MOV_RR8 : OP_MOV_MEM;
                end
                OPC_CMP_AL:
                begin
                    q_uop.op  = OP_CMP_AL;
                    q_uop.len = 2'd2;
                end
                OPC_JZ:
                begin
                    q_uop.op  = OP_JZ;
                    q_uop.len = 2'd2;
                end
                OPC_JNZ:
                begin
                    q_uop.op  = OP_JNZ;
                    q_uop.len = 2'd2;
                end
                OPC_JMP_SHORT:
                begin
                    q_uop.op  = OP_JMP;
                    q_uop.len = 2'd2;
                end
                OPC_PUSH_AX: q_uop.op = OP_PUSH;
                OPC_POP_AX:  q_uop.op = OP_POP;
                OPC_INT:
                begin
                    q_uop.op  = OP_INT;
                    q_uop.len = 2'd2;
                    if (operand_one == INT_SERVICE)
                        q_uop.trap = TRAP_SERVICE;
                    else if (operand_one == INT_TERMINATE)
                        q_uop.trap = TRAP_TERMINATE;
                    else
                        q_uop.trap = TRAP_OTHER;
                end
                OPC_IRET: q_uop.op = OP_IRET;
                OPC_RETF: q_uop.op = OP_RETF;
                OPC_RET:  q_uop.op = OP_RET;
                default:  q_uop.op = OP_UNKNOWN;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/xse_queue.sv @@
`default_nettype none

module xse_queue #(
    parameter int DEPTH = xse_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire xse_pkg::uop_t push_uop,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output xse_pkg::uop_t      head_uop
);
    import xse_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    uop_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_uop  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_uop;
    end

endmodule

`default_nettype wire

@@ hdl/xse_back.sv @@
`default_nettype none

module xse_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_not_empty,
    input  wire xse_pkg::uop_t q_uop,
    output logic               q_pop,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [15:0]        next_offset,
    output logic [15:0]        code_segment,
    output logic               mem_write,
    output logic [20:0]        write_address,
    output logic [15:0]        write_data,
    output logic [1:0]         trap_kind,
    output logic               recognized,
    output logic [15:0]        acc_value,
    output logic [15:0]        data_value,
    output logic [15:0]        flags_value
);
    import xse_pkg::*;

    // AX, CX, DX, BX kept as byte halves; BP, SI, DI are never read by the subset
    logic [7:0]  lo_reg [4];
    logic [7:0]  hi_reg [4];
    logic [7:0]  lo_next [4];
    logic [7:0]  hi_next [4];
    logic [15:0] sp_reg, sp_next;
    logic [15:0] ip_reg, ip_next;
    logic [15:0] cs_reg, cs_next;
    logic [15:0] ss_reg, ss_next;
    logic [15:0] flags_reg, flags_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] offset_reg;
    logic [15:0] cs_out_reg;
    logic        mem_write_reg, mem_write_next;
    logic [20:0] waddr_reg, waddr_next;
    logic [15:0] wdata_reg, wdata_next;
    logic [1:0]  trap_reg;
    logic        known_reg;
    logic [15:0] acc_reg;
    logic [15:0] data_reg;
    logic [15:0] flags_out_reg;

    logic        byte_we;
    logic [2:0]  byte_idx;
    logic [7:0]  byte_data;
    logic        word_we;
    logic [1:0]  word_idx;
    logic [15:0] word_data;

    logic [15:0] ip_seq;
    logic [15:0] ip_rel;
    logic [7:0]  src_byte;
    logic [8:0]  cmp_diff;
    logic [15:0] sp_push;

    assign q_pop = q_not_empty && (!out_valid_reg || out_ready);

    assign ip_seq   = ip_reg + {14'd0, q_uop.len};
    assign ip_rel   = ip_reg + 16'd2 + {{8{q_uop.imm[7]}}, q_uop.imm[7:0]};
    assign src_byte = q_uop.src[2] ? hi_reg[q_uop.src[1:0]] : lo_reg[q_uop.src[1:0]];
    assign cmp_diff = {1'b0, lo_reg[0]} - {1'b0, q_uop.imm[7:0]};
    assign sp_push  = sp_reg - 16'd2;

    always_comb
    begin
        ip_next    = ip_reg;
        cs_next    = cs_reg;
        sp_next    = sp_reg;
        ss_next    = ss_reg;
        flags_next = flags_reg;
        byte_we    = 1'b0;
        byte_idx   = q_uop.dst;
        byte_data  = q_uop.imm[7:0];
        word_we    = 1'b0;
        word_idx   = q_uop.dst[1:0];
        word_data  = q_uop.imm;
        mem_write_next = 1'b0;
        waddr_next = '0;
        wdata_next = '0;

        if (q_pop)
        begin
            ip_next = ip_seq;
            unique case (q_uop.op)
                OP_NOP, OP_MOV_MEM, OP_INT, OP_UNKNOWN: ;
                OP_MOV_R8_IMM: byte_we = 1'b1;
                OP_MOV_R16_IMM:
                begin
                    if (q_uop.dst == REG_SP)
                        sp_next = q_uop.imm;
                    else
                        word_we = !q_uop.dst[2];
                end
                OP_MOV_RR8:
                begin
                    byte_we   = 1'b1;
                    byte_data = src_byte;
                end
                OP_CMP_AL:
                begin
                    flags_next[CF_POS] = cmp_diff[8];
                    flags_next[ZF_POS] = (cmp_diff[7:0] == 8'd0);
                    flags_next[SF_POS] = cmp_diff[7];
                end
                OP_JZ:  ip_next = flags_reg[ZF_POS] ? ip_rel : ip_seq;
                OP_JNZ: ip_next = flags_reg[ZF_POS] ? ip_seq : ip_rel;
                OP_JMP: ip_next = ip_rel;
                OP_PUSH:
                begin
                    sp_next        = sp_push;
                    mem_write_next = 1'b1;
                    waddr_next     = {1'b0, ss_reg, 4'd0} + {5'd0, sp_push};
                    wdata_next     = {hi_reg[0], lo_reg[0]};
                end
                OP_POP:
                begin
                    word_we   = 1'b1;
                    word_idx  = 2'd0;
                    word_data = q_uop.top;
                    sp_next   = sp_reg + 16'd2;
                end
                OP_IRET:
                begin
                    ip_next    = q_uop.top;
                    cs_next    = q_uop.second;
                    flags_next = q_uop.third;
                    sp_next    = sp_reg + 16'd6;
                end
                OP_RETF:
                begin
                    ip_next = q_uop.top;
                    cs_next = q_uop.second;
                    sp_next = sp_reg + 16'd4;
                end
                OP_RET:
                begin
                    ip_next = q_uop.top;
                    sp_next = sp_reg + 16'd2;
                end
            endcase
        end

        // start registers load the live state at once
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_CS:  cs_next = cfg_data;
                CFG_START_IP:  ip_next = cfg_data;
                CFG_START_SP:  sp_next = cfg_data;
                CFG_STACK_SEG: ss_next = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lo_next[i] = lo_reg[i];
            hi_next[i] = hi_reg[i];
            if (word_we && word_idx == 2'(i))
            begin
                lo_next[i] = word_data[7:0];
                hi_next[i] = word_data[15:8];
            end
            else if (byte_we && byte_idx[1:0] == 2'(i))
            begin
                if (byte_idx[2])
                    hi_next[i] = byte_data;
                else
                    lo_next[i] = byte_data;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
            sp_reg        <= RST_SP;
            ip_reg        <= RST_IP;
            cs_reg        <= RST_CS;
            ss_reg        <= RST_SS;
            flags_reg     <= RST_FLAGS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            sp_reg        <= sp_next;
            ip_reg        <= ip_next;
            cs_reg        <= cs_next;
            ss_reg        <= ss_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            offset_reg    <= ip_next;
            cs_out_reg    <= cs_next;
            mem_write_reg <= mem_write_next;
            waddr_reg     <= waddr_next;
            wdata_reg     <= wdata_next;
            trap_reg      <= q_uop.trap;
            known_reg     <= (q_uop.op != OP_UNKNOWN);
            acc_reg       <= {hi_next[0], lo_next[0]};
            data_reg      <= {hi_next[2], lo_next[2]};
            flags_out_reg <= flags_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_offset   = offset_reg;
    assign code_segment  = cs_out_reg;
    assign mem_write     = mem_write_reg;
    assign write_address = waddr_reg;
    assign write_data    = wdata_reg;
    assign trap_kind     = trap_reg;
    assign recognized    = known_reg;
    assign acc_value     = acc_reg;
    assign data_value    = data_reg;
    assign flags_value   = flags_out_reg;

endmodule

`default_nettype wire

@@ verif/tb_x86_subset_instruction_executor.sv @@
`default_nettype none

module tb_x86_subset_instruction_executor;

    import xse_pkg::*;

    // One instruction request: fetched bytes plus the three words at SS:SP
    typedef struct packed {
        logic [7:0]  op;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [15:0] top;
        logic [15:0] second;
        logic [15:0] third;
    } instr_t;

    // Architectural outcome of one retired instruction
    typedef struct packed {
        logic [15:0] next_ip;
        logic [15:0] cs;
        logic        mem_wr;
        logic [20:0] wr_addr;
        logic [15:0] wr_data;
        logic [1:0]  trap;
        logic        known;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [15:0] flags;
    } exec_result_t;

    // Directed table row; 'typed' rows carry a hand-written outcome
    typedef struct packed {
        instr_t       ins;
        logic         typed;
        exec_result_t want;
    } dir_row_t;

    localparam int RANDOM_PER_PHASE = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  opcode;
    logic [7:0]  operand_one;
    logic [7:0]  operand_two;
    logic [15:0] stack_top;
    logic [15:0] stack_second;
    logic [15:0] stack_third;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] next_offset;
    logic [15:0] code_segment;
    logic        mem_write;
    logic [20:0] write_address;
    logic [15:0] write_data;
    logic [1:0]  trap_kind;
    logic        recognized;
    logic [15:0] acc_value;
    logic [15:0] data_value;
    logic [15:0] flags_value;

    // Shadow machine state, advanced once per accepted request
    logic [15:0] gpr [8];
    logic [15:0] ip_now;
    logic [15:0] cs_now;
    logic [15:0] flags_now;
    logic [15:0] ss_now;

    // Outcomes of accepted requests, oldest first
    exec_result_t retire_queue [$];
    dir_row_t     directed_rows [$];

    int mismatches      = 0;
    int directed_issued = 0;
    int random_issued   = 0;
    int retired         = 0;
    int in_idle_pct     = 0;
    int stall_pct       = 0;

    x86_subset_instruction_executor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .operand_one   (operand_one),
        .operand_two   (operand_two),
        .stack_top     (stack_top),
        .stack_second  (stack_second),
        .stack_third   (stack_third),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .next_offset   (next_offset),
        .code_segment  (code_segment),
        .mem_write     (mem_write),
        .write_address (write_address),
        .write_data    (write_data),
        .trap_kind     (trap_kind),
        .recognized    (recognized),
        .acc_value     (acc_value),
        .data_value    (data_value),
        .flags_value   (flags_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Shadow machine
    // ---------------------------------------------------------------------

    // Byte registers: idx[2] picks the high half of AX/CX/DX/BX
    function automatic logic [7:0] get_byte(input logic [2:0] idx);
        return idx[2] ? gpr[idx[1:0]][15:8] : gpr[idx[1:0]][7:0];
    endfunction

    function automatic void put_byte(input logic [2:0] idx, input logic [7:0] v);
        if (idx[2])
            gpr[idx[1:0]][15:8] = v;
        else
            gpr[idx[1:0]][7:0] = v;
    endfunction

    // Short jump target: rel8 is sign-extended and counted from the next instruction
    function automatic logic [15:0] short_target(input logic [7:0] rel);
        return ip_now + 16'd2 + {{8{rel[7]}}, rel};
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < 8; i++)
            gpr[i] = 16'h0000;
        gpr[REG_SP] = RST_SP;
        ip_now      = RST_IP;
        cs_now      = RST_CS;
        flags_now   = RST_FLAGS;
        ss_now      = RST_SS;
    endfunction

    // Executes one instruction on the shadow state and returns what retires
    function automatic exec_result_t execute_instr(input instr_t it);
        exec_result_t res;
        logic [15:0]  sp;
        logic [7:0]   al;
        logic [7:0]   diff;
        res       = '0;
        res.known = 1'b1;
        sp        = gpr[REG_SP];
        if (it.op[7:3] == OPC_MOV_R8_HI)
        begin
            put_byte(it.op[2:0], it.b1);
            ip_now = ip_now + 16'd2;
        end
        else if (it.op[7:3] == OPC_MOV_R16_HI)
        begin
            gpr[it.op[2:0]] = {it.b2, it.b1};
            ip_now = ip_now + 16'd3;
        end
        else
        begin
            case (it.op)
                OPC_NOP:
                    ip_now = ip_now + 16'd1;
                OPC_MOV_RM8:
                begin
                    // memory forms only step past the modrm byte
                    if (it.b1[7:6] == MODRM_MOD_REG)
                        put_byte(it.b1[2:0], get_byte(it.b1[5:3]));
                    ip_now = ip_now + 16'd2;
                end
                OPC_CMP_AL:
                begin
                    al   = gpr[0][7:0];
                    diff = al - it.b1;
                    flags_now[CF_POS] = (al < it.b1);
                    flags_now[ZF_POS] = (diff == 8'h00);
                    flags_now[SF_POS] = diff[7];
                    ip_now = ip_now + 16'd2;
                end
                OPC_JZ:
                    ip_now = flags_now[ZF_POS] ? short_target(it.b1) : ip_now + 16'd2;
                OPC_JNZ:
                    ip_now = flags_now[ZF_POS] ? ip_now + 16'd2 : short_target(it.b1);
                OPC_JMP_SHORT:
                    ip_now = short_target(it.b1);
                OPC_PUSH_AX:
                begin
                    sp          = sp - 16'd2;
                    gpr[REG_SP] = sp;
                    res.mem_wr  = 1'b1;
                    res.wr_addr = {1'b0, ss_now, 4'h0} + {5'h00, sp};
                    res.wr_data = gpr[0];
                    ip_now      = ip_now + 16'd1;
                end
                OPC_POP_AX:
                begin
                    gpr[0]      = it.top;
                    gpr[REG_SP] = sp + 16'd2;
                    ip_now      = ip_now + 16'd1;
                end
                OPC_INT:
                begin
                    ip_now = ip_now + 16'd2;
                    if (it.b1 == INT_SERVICE)
                        res.trap = TRAP_SERVICE;
                    else if (it.b1 == INT_TERMINATE)
                        res.trap = TRAP_TERMINATE;
                    else
                        res.trap = TRAP_OTHER;
                end
                OPC_IRET:
                begin
                    ip_now      = it.top;
                    cs_now      = it.second;
                    flags_now   = it.third;
                    gpr[REG_SP] = sp + 16'd6;
                end
                OPC_RETF:
                begin
                    ip_now      = it.top;
                    cs_now      = it.second;
                    gpr[REG_SP] = sp + 16'd4;
                end
                OPC_RET:
                begin
                    ip_now      = it.top;
                    gpr[REG_SP] = sp + 16'd2;
                end
                default:
                begin
                    ip_now    = ip_now + 16'd1;
                    res.known = 1'b0;
                end
            endcase
        end
        res.next_ip = ip_now;
        res.cs      = cs_now;
        res.ax      = gpr[0];
        res.dx      = gpr[2];
        res.flags   = flags_now;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic dir_row_t row_plain(input logic [7:0] op, b1, b2,
                                           input logic [15:0] top, second, third);
        dir_row_t r;
        r       = '0;
        r.ins   = '{op: op, b1: b1, b2: b2, top: top, second: second, third: third};
        r.typed = 1'b0;
        return r;
    endfunction

    // Row whose outcome is written out by hand; none of these push
    function automatic dir_row_t row_typed(input logic [7:0] op, b1, b2,
                                           input logic [15:0] top, second, third,
                                           input logic [15:0] ip, cs,
                                           input logic [1:0] trap, input logic known,
                                           input logic [15:0] ax, dx, flags);
        dir_row_t r;
        r            = row_plain(op, b1, b2, top, second, third);
        r.typed      = 1'b1;
        r.want.next_ip = ip;
        r.want.cs    = cs;
        r.want.trap  = trap;
        r.want.known = known;
        r.want.ax    = ax;
        r.want.dx    = dx;
        r.want.flags = flags;
        return r;
    endfunction

    // Mostly supported opcodes with random operands; a tail of raw bytes as noise.
    // CMP often matches AL so ZF gets set and the conditional jumps go both ways.
    function automatic instr_t rand_instr();
        instr_t      it;
        int unsigned pick;
        it.b1     = 8'($urandom);
        it.b2     = 8'($urandom);
        it.top    = 16'($urandom);
        it.second = 16'($urandom);
        it.third  = 16'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 10)
            it.op = {OPC_MOV_R8_HI, 3'($urandom_range(0, 7))};
        else if (pick < 20)
            it.op = {OPC_MOV_R16_HI, 3'($urandom_range(0, 7))};
        else if (pick < 30)
        begin
            it.op = OPC_MOV_RM8;
            if ($urandom_range(0, 1) == 1)
                it.b1[7:6] = MODRM_MOD_REG;
        end
        else if (pick < 42)
        begin
            it.op = OPC_CMP_AL;
            if ($urandom_range(0, 2) == 0)
                it.b1 = gpr[0][7:0];
        end
        else if (pick < 50)
            it.op = OPC_JZ;
        else if (pick < 58)
            it.op = OPC_JNZ;
        else if (pick < 63)
            it.op = OPC_JMP_SHORT;
        else if (pick < 70)
            it.op = OPC_PUSH_AX;
        else if (pick < 76)
            it.op = OPC_POP_AX;
        else if (pick < 82)
        begin
            it.op = OPC_INT;
            case ($urandom_range(0, 2))
                0:       it.b1 = INT_SERVICE;
                1:       it.b1 = INT_TERMINATE;
                default: ;
            endcase
        end
        else if (pick < 85)
            it.op = OPC_IRET;
        else if (pick < 88)
            it.op = OPC_RETF;
        else if (pick < 92)
            it.op = OPC_RET;
        else if (pick < 95)
            it.op = OPC_NOP;
        else
            it.op = 8'($urandom);
        return it;
    endfunction

    // Presents one request and returns at the edge that accepts it. Valid is only
    // dropped when a gap is rolled, so back-to-back requests keep it high.
    task automatic issue_request(input instr_t it);
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < in_idle_pct);
        end
        in_valid     <= 1'b1;
        opcode       <= it.op;
        operand_one  <= it.b1;
        operand_two  <= it.b2;
        stack_top    <= it.top;
        stack_second <= it.second;
        stack_third  <= it.third;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop sending, let every outstanding result retire, then a little slack
    // for the two-stage pipe.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (retire_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_we high so a burst of writes never toggles it within one step
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        // start registers also load the live CS, IP and SP
        case (idx)
            CFG_START_CS:  cs_now      = val;
            CFG_START_IP:  ip_now      = val;
            CFG_START_SP:  gpr[REG_SP] = val;
            CFG_STACK_SEG: ss_now      = val;
            default:       ;
        endcase
    endtask

    task automatic load_start_regs(input logic [15:0] cs, ip, sp, ss);
        cfg_write(CFG_START_CS, cs);
        cfg_write(CFG_START_IP, ip);
        cfg_write(CFG_START_SP, sp);
        cfg_write(CFG_STACK_SEG, ss);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    // One line per mismatch, and a running count
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [20:0] got, want);
        if (got !== want)
            report_mismatch($sformatf("retire %0d %s got %0h want %0h",
                                      retired, name, got, want));
    endtask

    // Receiver: checks each result at its handshake edge, then rolls the stall
    // for the next cycle. Values read here are the ones from before the edge.
    always @(posedge clk)
    begin : retire_check
        exec_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (retire_queue.size() == 0)
                report_mismatch($sformatf("result with no request outstanding, ip %0h",
                                          next_offset));
            else
            begin
                want = retire_queue.pop_front();
                check_field("next_offset",   21'(next_offset),   21'(want.next_ip));
                check_field("code_segment",  21'(code_segment),  21'(want.cs));
                check_field("mem_write",     21'(mem_write),     21'(want.mem_wr));
                check_field("write_address", write_address,      want.wr_addr);
                check_field("write_data",    21'(write_data),    21'(want.wr_data));
                check_field("trap_kind",     21'(trap_kind),     21'(want.trap));
                check_field("recognized",    21'(recognized),    21'(want.known));
                check_field("acc_value",     21'(acc_value),     21'(want.ax));
                check_field("data_value",    21'(data_value),    21'(want.dx));
                check_field("flags_value",   21'(flags_value),   21'(want.flags));
                retired++;
            end
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hard stop far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin : main_seq
        instr_t       it;
        dir_row_t     row;
        exec_result_t predicted;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_START_CS;
        cfg_data     <= 16'h0000;
        in_valid     <= 1'b0;
        opcode       <= OPC_NOP;
        operand_one  <= 8'h00;
        operand_two  <= 8'h00;
        stack_top    <= 16'h0000;
        stack_second <= 16'h0000;
        stack_third  <= 16'h0000;
        out_ready    <= 1'b0;
        shadow_reset();

        // Directed table, run from the reset state. The first rows are typed:
        // NOP, the three trap codes, an unknown opcode, AX/DX at all ones, then
        // IRET and RETF to extreme CS:IP with SP wrapping, and IP wrapping to 0.
        directed_rows.push_back(row_typed(OPC_NOP, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0,
            16'h0101, 16'h2000, TRAP_NONE, 1'b1, 16'h0000, 16'h0000, 16'h0200));
        directed_rows.push_back(row_typed(OPC_INT, INT_SERVICE, 8'h00, 16'h0, 16'h0, 16'h0,
            16'h0103, 16'h2000, TRAP_SERVICE, 1'b1, 16'h0000, 16'h0000, 16'h0200));
        directed_rows.push_back(row_typed(OPC_INT, INT_TERMINATE, 8'h00, 16'h0, 16'h0, 16'h0,
            16'h0105, 16'h2000, TRAP_TERMINATE, 1'b1, 16'h0000, 16'h0000, 16'h0200));
        directed_rows.push_back(row_typed(OPC_INT, 8'hFF, 8'h00, 16'h0, 16'h0, 16'h0,
            16'h0107, 16'h2000, TRAP_OTHER, 1'b1, 16'h0000, 16'h0000, 16'h0200));
        directed_rows.push_back(row_typed(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'h0108, 16'h2000, TRAP_NONE, 1'b0, 16'h0000, 16'h0000, 16'h0200));
        directed_rows.push_back(row_typed({OPC_MOV_R16_HI, 3'd0}, 8'hFF, 8'hFF,
            16'h0, 16'h0, 16'h0,
            16'h010B, 16'h2000, TRAP_NONE, 1'b1, 16'hFFFF, 16'h0000, 16'h0200));
        directed_rows.push_back(row_typed({OPC_MOV_R16_HI, 3'd2}, 8'hFF, 8'hFF,
            16'h0, 16'h0, 16'h0,
            16'h010E, 16'h2000, TRAP_NONE, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0200));
        directed_rows.push_back(row_typed(OPC_IRET, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF,
            16'h0000, 16'hFFFF, TRAP_NONE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(row_typed(OPC_RETF, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 16'h0,
            16'hFFFF, 16'h0000, TRAP_NONE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(row_typed(OPC_NOP, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0,
            16'h0000, 16'h0000, TRAP_NONE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Remaining rows go through the shadow machine: stack ops, byte moves
        // (register and memory forms), CMP equal / borrow / sign, both outcomes
        // of JZ and JNZ, and a jump back onto itself.
        directed_rows.push_back(row_plain(OPC_PUSH_AX, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_POP_AX, 8'h00, 8'h00, 16'h1234, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_RET, 8'h00, 8'h00, 16'hFFFE, 16'h0, 16'h0));
        directed_rows.push_back(row_plain({OPC_MOV_R8_HI, 3'd0}, 8'h80, 8'h00,
                                          16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_MOV_RM8, 8'hC2, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_MOV_RM8, 8'hE7, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_MOV_RM8, 8'h3F, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_CMP_AL, 8'h80, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_JZ, 8'hF0, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_JNZ, 8'h10, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_CMP_AL, 8'h81, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_JNZ, 8'h80, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_JZ, 8'h7F, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_CMP_AL, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0));
        directed_rows.push_back(row_plain(OPC_JMP_SHORT, 8'hFE, 8'h00, 16'h0, 16'h0, 16'h0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: no idling on either side
        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            issue_request(row.ins);
            predicted = execute_instr(row.ins);
            if (row.typed)
            begin
                if (predicted !== row.want)
                    report_mismatch($sformatf("directed row %0d: shadow state disagrees", n));
                retire_queue.push_back(row.want);
            end
            else
                retire_queue.push_back(predicted);
            directed_issued++;
        end
        wait_quiet();

        // Random part, four phases. Each phase reloads every start register
        // while idle and picks its own idling mix:
        //   0: all-zero start regs, no idling
        //   1: all-ones start regs, sender idle 69%
        //   2: random start regs, receiver stalling 69%
        //   3: reset values again, both sides at 33%
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    load_start_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                    in_idle_pct = 0;
                    stall_pct   = 0;
                end
                1:
                begin
                    load_start_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    in_idle_pct = 69;
                    stall_pct   = 0;
                end
                2:
                begin
                    load_start_regs(16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
                    in_idle_pct = 0;
                    stall_pct   = 69;
                end
                default:
                begin
                    load_start_regs(RST_CS, RST_IP, RST_SP, RST_SS);
                    in_idle_pct = 33;
                    stall_pct   = 33;
                end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                it = rand_instr();
                issue_request(it);
                retire_queue.push_back(execute_instr(it));
                random_issued++;
            end
            wait_quiet();
        end

        repeat (8) @(posedge clk);

        $display("ran %0d directed and %0d random instructions, %0d checked, %0d mismatches",
                 directed_issued, random_issued, retired, mismatches);
        $display("start registers at zero, all ones, random and reset; four idle mixes");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
